[hw/rtl/spsel_pkg.sv]
// Shared types, mode codes and constants for the simplex pivot selector.
// No dependencies; every other file imports this package.
package spsel_pkg;

    localparam int MAX_ELEMENTS_DEF = 1024;
    localparam int FRAC_BITS_DEF    = 16;

    localparam int KEY_W   = 48;
    localparam int POS_W   = 10;
    localparam int VAR_W   = 16;
    localparam int TOL_W   = 31;
    localparam int MODE_W  = 3;
    localparam int DVD_W   = 64;
    localparam int DVS_W   = 32;
    localparam int CIDX_W  = 2;

    localparam logic [MODE_W-1:0] MODE_RATIO  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_BLAND  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_DZ     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DZ_NEG = 3'd3;
    localparam logic [MODE_W-1:0] MODE_STEEP  = 3'd4;

    localparam logic [CIDX_W-1:0] REG_RULE_MODE = 2'd0;
    localparam logic [CIDX_W-1:0] REG_TOLERANCE = 2'd1;

    localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};

    typedef struct packed {
        logic signed [31:0] value;
        logic signed [31:0] denom;
        logic [31:0]        weight;
        logic [VAR_W-1:0]   var_id;
        logic               last;
    } item_t;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic [VAR_W-1:0] chosen_var;
        logic             found;
    } result_t;

    typedef struct packed {
        logic              qual;
        logic              divide;
        logic [MODE_W-1:0] mode;
        logic [DVD_W-1:0]  dividend;
        logic [DVS_W-1:0]  divisor;
        logic [KEY_W-1:0]  key;
        logic [VAR_W-1:0]  var_id;
        logic [POS_W-1:0]  pos;
        logic              last;
    } entry_t;

endpackage

[hw/rtl/simplex_pivot_selector.sv]
// Top level of the simplex pivot selector: configuration registers and the
// front end, queue and back end. Depends on spsel_pkg and the spsel_* modules.
//
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------
//  input    | push / full            | item   (item_t)
//  result   | pop / empty            | result (result_t), one per last
//  config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// Qualifying ratio test and steepest edge elements with a nonzero divisor pass
// through the 64-step divider in the back end (one bit per cycle); all other
// elements bypass the divider and go straight to the update state.
// The two-entry queue lets the front accept while the back divides.
// Reset clears control state and sets rule_mode 0, tolerance 1.
// A waiting result stalls the back end only at the next last element.
module simplex_pivot_selector
    import spsel_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  item_t             item,
    output logic              empty,
    input  logic              pop,
    output result_t           result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [TOL_W-1:0]  cfg_data
);

    logic [MODE_W-1:0] mode_reg;
    logic [TOL_W-1:0]  tol_reg;
    logic              accept;
    entry_t            f_entry;
    entry_t            q_data;
    logic              q_valid;
    logic              q_pop;

    assign cfg_ready = 1'b1;
    assign accept    = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_RATIO;
            tol_reg  <= TOL_W'(1);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_RULE_MODE: mode_reg <= cfg_data[MODE_W-1:0];
                REG_TOLERANCE: tol_reg  <= cfg_data;
                default:       ;
            endcase
        end
    end

    spsel_front #(
        .MAX_ELEMENTS(MAX_ELEMENTS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .item     (item),
        .mode     (mode_reg),
        .tolerance(tol_reg),
        .entry    (f_entry)
    );

    spsel_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (accept),
        .wr_data(f_entry),
        .full   (full),
        .rd     (q_pop),
        .valid  (q_valid),
        .rd_data(q_data)
    );

    spsel_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .q_pop    (q_pop),
        .tolerance(tol_reg),
        .empty    (empty),
        .pop      (pop),
        .result   (result)
    );

endmodule

[hw/rtl/spsel_front.sv]
// Front end: accepts elements, tracks position, qualifies them and forms keys
// or divide operands. Depends on spsel_pkg.
module spsel_front
    import spsel_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  item_t             item,
    input  logic [MODE_W-1:0] mode,
    input  logic [TOL_W-1:0]  tolerance,
    output entry_t            entry
);

    localparam int CNT_W = (MAX_ELEMENTS > 2) ? $clog2(MAX_ELEMENTS) : 1;

    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [CNT_W:0]    cnt_inc;
    logic signed [31:0] tol_s;
    logic signed [31:0] neg_tol;
    logic               v_neg;
    logic [31:0]        mag;
    logic [63:0]        sq;

    assign tol_s   = $signed({1'b0, tolerance});
    assign neg_tol = -tol_s;
    assign v_neg   = item.value < neg_tol;
    assign mag     = 32'(~item.value + 32'sd1);
    assign sq      = 64'(mag) * 64'(mag);
    assign cnt_inc = {1'b0, cnt_reg} + 1'b1;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (accept)
        begin
            if (item.last || (32'(cnt_inc) >= MAX_ELEMENTS))
                cnt_next = '0;
            else
                cnt_next = cnt_inc[CNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_comb
    begin
        entry          = '0;
        entry.mode     = mode;
        entry.var_id   = item.var_id;
        entry.pos      = POS_W'(cnt_reg);
        entry.last     = item.last;
        case (mode)
            MODE_RATIO:
            begin
                entry.qual    = item.denom > tol_s;
                entry.divide  = 1'b1;
                entry.divisor = item.denom;
                if (item.value > 32'sd0)
                    entry.dividend = DVD_W'(item.value[30:0]) << FRAC_BITS;
            end
            MODE_BLAND:
                entry.qual = v_neg;
            MODE_DZ, MODE_DZ_NEG:
            begin
                entry.qual = 1'b1;
                entry.key  = KEY_W'({~item.value[31], item.value[30:0]});
            end
            MODE_STEEP:
            begin
                entry.qual     = v_neg;
                entry.divide   = 1'b1;
                entry.dividend = sq;
                entry.divisor  = (item.weight > 32'(tolerance)) ? item.weight
                                                                 : 32'(tolerance);
            end
            default:
                entry.qual = 1'b0;
        endcase
    end

endmodule

[hw/rtl/spsel_queue.sv]
// Two-entry queue that decouples the front end from the back end.
// Depends on spsel_pkg.
module spsel_queue
    import spsel_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   wr,
    input  entry_t wr_data,
    output logic   full,
    input  logic   rd,
    output logic   valid,
    output entry_t rd_data
);

    entry_t     mem [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;

    assign full    = cnt_reg == 2'd2;
    assign valid   = cnt_reg != 2'd0;
    assign rd_data = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr)
            mem[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr)
                wp_reg <= ~wp_reg;
            if (rd)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(wr) - 2'(rd);
        end
    end

endmodule

[hw/rtl/spsel_back.sv]
// Back end: bit-serial divider, best-candidate compare and result register.
// Depends on spsel_pkg.
module spsel_back
    import spsel_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  entry_t           q_data,
    output logic             q_pop,
    input  logic [TOL_W-1:0] tolerance,
    output logic             empty,
    input  logic             pop,
    output result_t          result
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;
    localparam int STEP_W = $clog2(DVD_W);

    logic [1:0]        state_reg, state_next;
    entry_t            ent_reg, ent_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [DVS_W-1:0]  rem_reg, rem_next;
    logic [DVD_W-1:0]  quo_reg, quo_next;
    logic [KEY_W-1:0]  bkey_reg, bkey_next;
    logic [VAR_W-1:0]  bvar_reg, bvar_next;
    logic [POS_W-1:0]  bpos_reg, bpos_next;
    logic              have_reg, have_next;
    result_t           out_reg, out_next;
    logic              outv_reg, outv_next;

    logic [DVS_W:0]    trial;
    logic              ge;
    logic              better;
    logic              found;
    logic [KEY_W-1:0]  nkey;
    logic [VAR_W-1:0]  nvar;
    logic [POS_W-1:0]  npos;
    logic              nhave;

    assign empty  = ~outv_reg;
    assign result = out_reg;
    assign trial  = {rem_reg, quo_reg[DVD_W-1]};
    assign ge     = trial >= {1'b0, ent_reg.divisor};

    always_comb
    begin
        case (ent_reg.mode)
            MODE_RATIO:
                better = !have_reg || key_reg < bkey_reg
                         || (key_reg == bkey_reg && ent_reg.var_id < bvar_reg);
            MODE_BLAND:
                better = !have_reg || ent_reg.var_id < bvar_reg;
            MODE_DZ, MODE_DZ_NEG:
                better = !have_reg || key_reg < bkey_reg;
            MODE_STEEP:
                better = !have_reg || key_reg > bkey_reg;
            default:
                better = 1'b0;
        endcase
        better = better && ent_reg.qual;
        nkey  = better ? key_reg : bkey_reg;
        nvar  = better ? ent_reg.var_id : bvar_reg;
        npos  = better ? ent_reg.pos : bpos_reg;
        nhave = better || have_reg;
        found = nhave;
        if (ent_reg.mode == MODE_DZ_NEG
            && !((49'(nkey) + 49'(tolerance)) < (49'd1 << 31)))
            found = 1'b0;
    end

    always_comb
    begin
        state_next = state_reg;
        ent_next   = ent_reg;
        key_next   = key_reg;
        step_next  = step_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        bkey_next  = bkey_reg;
        bvar_next  = bvar_reg;
        bpos_next  = bpos_reg;
        have_next  = have_reg;
        out_next   = out_reg;
        outv_next  = outv_reg && !pop;
        q_pop      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    ent_next  = q_data;
                    rem_next  = '0;
                    quo_next  = q_data.dividend;
                    step_next = {STEP_W{1'b1}};
                    if (q_data.qual && q_data.divide && q_data.divisor != '0)
                        state_next = S_DIV;
                    else
                    begin
                        key_next   = q_data.divide ? KEY_MAX : q_data.key;
                        state_next = S_UPD;
                    end
                end
            end
            S_DIV:
            begin
                rem_next  = ge ? DVS_W'(trial - {1'b0, ent_reg.divisor}) : trial[DVS_W-1:0];
                quo_next  = {quo_reg[DVD_W-2:0], ge};
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    key_next   = (|quo_next[DVD_W-1:KEY_W]) ? KEY_MAX
                                                              : quo_next[KEY_W-1:0];
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                if (!(ent_reg.last && outv_reg && !pop))
                begin
                    state_next = S_IDLE;
                    if (ent_reg.last)
                    begin
                        out_next.found      = found;
                        out_next.position   = found ? npos : '0;
                        out_next.chosen_var = found ? nvar : '0;
                        outv_next = 1'b1;
                        bkey_next = '0;
                        bvar_next = '0;
                        bpos_next = '0;
                        have_next = 1'b0;
                    end
                    else
                    begin
                        bkey_next = nkey;
                        bvar_next = nvar;
                        bpos_next = npos;
                        have_next = nhave;
                    end
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            have_reg  <= 1'b0;
            outv_reg  <= 1'b0;
            bkey_reg  <= '0;
            bvar_reg  <= '0;
            bpos_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            have_reg  <= have_next;
            outv_reg  <= outv_next;
            bkey_reg  <= bkey_next;
            bvar_reg  <= bvar_next;
            bpos_reg  <= bpos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg  <= ent_next;
        key_reg  <= key_next;
        step_reg <= step_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        out_reg  <= out_next;
    end

endmodule

[tb/tb_simplex_pivot_selector.sv]
// Self-checking testbench for simplex_pivot_selector: directed and random vectors
// under every pivot rule, checked against an in-bench predictor. Depends on spsel_pkg.
module tb_simplex_pivot_selector;
    import spsel_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  LIMIT     = 1000000;
    localparam int  DRAIN     = 300;
    localparam int  N_RANDOM  = 240;

    logic              clk;
    logic              rst_n;
    logic              push;
    logic              full;
    item_t             item;
    logic              empty;
    logic              pop;
    result_t           result;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CIDX_W-1:0] cfg_index;
    logic [TOL_W-1:0]  cfg_data;

    simplex_pivot_selector dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state
    logic [MODE_W-1:0] sel_mode;
    logic [TOL_W-1:0]  sel_tol;
    logic [POS_W-1:0]  elem_pos;
    logic [KEY_W-1:0]  best_key;
    logic [VAR_W-1:0]  best_var;
    logic [POS_W-1:0]  best_pos;
    logic              have_best;

    result_t pivot_expect[$];
    int      errors;
    int      items_sent;
    int      pivots_checked;
    int      cycles;
    int      send_idle_pct;
    int      pop_stall_pct;

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic logic [KEY_W-1:0] sat_key(logic [63:0] x);
        return (x > {16'd0, KEY_MAX}) ? KEY_MAX : x[KEY_W-1:0];
    endfunction

    function automatic item_t mk(logic [31:0] v, logic [31:0] d, logic [31:0] w,
                                 logic [VAR_W-1:0] id, logic lst);
        item_t it;
        it.value  = v;
        it.denom  = d;
        it.weight = w;
        it.var_id = id;
        it.last   = lst;
        return it;
    endfunction

    task automatic keep_best(logic [KEY_W-1:0] key, logic [VAR_W-1:0] id);
        best_key  = key;
        best_var  = id;
        best_pos  = elem_pos;
        have_best = 1'b1;
    endtask

    task automatic predict_pivot(item_t it);
        longint      v;
        longint      d;
        longint      tol;
        logic [63:0] num;
        logic [63:0] mag;
        logic [63:0] dv;
        logic [KEY_W-1:0] key;
        result_t     r;
        logic        fnd;
        v   = it.value;
        d   = it.denom;
        tol = longint'(sel_tol);
        case (sel_mode)
            MODE_RATIO:
                if (d > tol)
                begin
                    num = (v > 0) ? v : 0;
                    key = sat_key((num << FRAC_BITS_DEF) / d);
                    if (!have_best || key < best_key || (key == best_key && it.var_id < best_var))
                        keep_best(key, it.var_id);
                end
            MODE_BLAND:
                if (v < -tol && (!have_best || it.var_id < best_var))
                    keep_best('0, it.var_id);
            MODE_DZ, MODE_DZ_NEG:
            begin
                num = v + 64'h8000_0000;
                key = num[KEY_W-1:0];
                if (!have_best || key < best_key)
                    keep_best(key, it.var_id);
            end
            MODE_STEEP:
                if (v < -tol)
                begin
                    mag = -v;
                    dv  = (it.weight > sel_tol) ? it.weight : sel_tol;
                    key = (dv == 0) ? KEY_MAX : sat_key((mag * mag) / dv);
                    if (!have_best || key > best_key)
                        keep_best(key, it.var_id);
                end
            default:
                ;
        endcase
        elem_pos = elem_pos + 1'b1;
        if (it.last)
        begin
            fnd = have_best;
            if (fnd && sel_mode == MODE_DZ_NEG)
                if (!((longint'(best_key) - 64'sh8000_0000) < -tol))
                    fnd = 1'b0;
            r.position   = fnd ? best_pos : '0;
            r.chosen_var = fnd ? best_var : '0;
            r.found      = fnd;
            pivot_expect = {pivot_expect, r};
            elem_pos  = '0;
            best_key  = '0;
            best_var  = '0;
            best_pos  = '0;
            have_best = 1'b0;
        end
    endtask

    task automatic send_item(item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        item <= it;
        do
            @(posedge clk);
        while (full);
        predict_pivot(it);
        items_sent++;
    endtask

    task automatic drain();
        push <= 1'b0;
        while (pivot_expect.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic write_reg(logic [CIDX_W-1:0] idx, logic [TOL_W-1:0] data);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_RULE_MODE)
            sel_mode = data[MODE_W-1:0];
        else if (idx == REG_TOLERANCE)
            sel_tol = data;
    endtask

    task automatic set_mode(logic [MODE_W-1:0] m);
        logic [TOL_W-1:0] data;
        data = TOL_W'($urandom);
        data[MODE_W-1:0] = m;
        write_reg(REG_RULE_MODE, data);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (pivot_expect.size() == 0)
                begin
                    $error("unexpected result transfer");
                    errors++;
                end
                else
                begin
                    if (result.position !== pivot_expect[0].position)
                    begin
                        $error("position: expected %0d, got %0d",
                               pivot_expect[0].position, result.position);
                        errors++;
                    end
                    if (result.chosen_var !== pivot_expect[0].chosen_var)
                    begin
                        $error("chosen_var: expected %0d, got %0d",
                               pivot_expect[0].chosen_var, result.chosen_var);
                        errors++;
                    end
                    if (result.found !== pivot_expect[0].found)
                    begin
                        $error("found: expected %0d, got %0d",
                               pivot_expect[0].found, result.found);
                        errors++;
                    end
                    void'(pivot_expect.pop_front());
                    pivots_checked++;
                end
            end
            pop <= ($urandom_range(99) >= pop_stall_pct);
        end
    end

    task automatic test_ratio();
        set_mode(MODE_RATIO);
        write_reg(REG_TOLERANCE, 1);
        send_item(mk(32'h7FFF_FFFF, 32'd2, 0, 16'd9, 0));
        send_item(mk(32'h0001_0000, 32'h0002_0000, 0, 16'd7, 0));
        send_item(mk(32'h0001_0000, 32'h0002_0000, 0, 16'd3, 0));
        send_item(mk(32'h8000_0000, 32'h7FFF_FFFF, 0, 16'd5, 0));
        send_item(mk(32'h0000_0100, 32'd1, 0, 16'd0, 1));
        write_reg(REG_TOLERANCE, 0);
        send_item(mk(32'h7FFF_FFFF, 32'd1, 0, 16'hFFFF, 0));
        send_item(mk(32'h7FFF_FFFF, 32'h8000_0000, 0, 16'd1, 1));
    endtask

    task automatic test_bland();
        set_mode(MODE_BLAND);
        write_reg(REG_TOLERANCE, 32'h0000_8000);
        send_item(mk(32'hFFFF_0000, 0, 0, 16'd40, 0));
        send_item(mk(32'hFFFF_0000, 0, 0, 16'd12, 0));
        send_item(mk(32'hFFFF_8000, 0, 0, 16'd2, 0));
        send_item(mk(32'hFFFF_0000, 0, 0, 16'd12, 1));
    endtask

    task automatic test_dantzig();
        set_mode(MODE_DZ);
        send_item(mk(32'h0000_0005, 0, 0, 16'd1, 0));
        send_item(mk(32'h8000_0000, 0, 0, 16'd2, 0));
        send_item(mk(32'h8000_0000, 0, 0, 16'd3, 1));
        set_mode(MODE_DZ_NEG);
        write_reg(REG_TOLERANCE, 32'h7FFF_FFFF);
        send_item(mk(32'h8000_0000, 0, 0, 16'd4, 1));
        send_item(mk(32'h8000_0001, 0, 0, 16'd5, 1));
        write_reg(REG_TOLERANCE, 1);
        send_item(mk(32'h0000_0000, 0, 0, 16'd6, 1));
    endtask

    task automatic test_steep();
        set_mode(MODE_STEEP);
        write_reg(REG_TOLERANCE, 0);
        send_item(mk(32'hFFFF_0000, 0, 32'h0001_0000, 16'd1, 0));
        send_item(mk(32'h8000_0000, 0, 32'd0, 16'd2, 0));
        send_item(mk(32'h8000_0000, 0, 32'hFFFF_FFFF, 16'd3, 1));
    endtask

    task automatic test_unused_and_index();
        for (int m = 5; m <= 7; m++)
        begin
            set_mode(m);
            send_item(mk(32'h8000_0000, 32'h7FFF_FFFF, 0, 16'd1, 1));
        end
        write_reg(2'd2, 31'h5);
        write_reg(2'd3, 31'h7FFF_FFFF);
        send_item(mk(32'h8000_0000, 32'h7FFF_FFFF, 0, 16'd1, 1));
    endtask

    task automatic test_mode_switch();
        set_mode(MODE_STEEP);
        write_reg(REG_TOLERANCE, 1);
        send_item(mk(32'hFFFE_0000, 0, 32'h0001_0000, 16'd8, 0));
        set_mode(MODE_DZ_NEG);
        send_item(mk(32'h0000_1000, 0, 0, 16'd9, 0));
        set_mode(MODE_BLAND);
        send_item(mk(32'hFFF0_0000, 0, 0, 16'd3, 1));
    endtask

    task automatic test_wrap();
        set_mode(MODE_DZ);
        for (int i = 0; i < MAX_ELEMENTS_DEF + 10; i++)
            send_item(mk((i == MAX_ELEMENTS_DEF + 4) ? 32'h8000_0000 : $urandom_range(1000),
                         0, 0, i[15:0], i == MAX_ELEMENTS_DEF + 9));
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0:       return 32'h8000_0000 + $urandom_range(3);
            1:       return 32'h7FFF_FFFF - $urandom_range(3);
            2:       return $urandom_range(8) - 4;
            3:       return {{12{$urandom_range(1) == 1}}, 20'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    task automatic test_random(int idle, int stall, int quota);
        int goal;
        int len;
        logic [TOL_W-1:0] tol;
        goal = items_sent + quota;
        send_idle_pct = idle;
        pop_stall_pct = stall;
        while (items_sent < goal)
        begin
            set_mode(($urandom_range(9) == 0) ? $urandom_range(5, 7) : $urandom_range(4));
            case ($urandom_range(3))
                0:       tol = 0;
                1:       tol = 1;
                2:       tol = $urandom_range(32'h0002_0000);
                default: tol = ($urandom_range(7) == 0) ? 31'h7FFF_FFFF : 31'($urandom);
            endcase
            write_reg(REG_TOLERANCE, tol);
            repeat (3)
            begin
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++)
                    send_item(mk(rand_word(), rand_word(), rand_word(),
                                 ($urandom_range(3) == 0) ? 16'($urandom_range(3)) : 16'($urandom),
                                 i == len - 1));
            end
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        push      = 1'b0;
        item      = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        sel_mode  = MODE_RATIO;
        sel_tol   = 1;
        elem_pos  = '0;
        best_key  = '0;
        best_var  = '0;
        best_pos  = '0;
        have_best = 1'b0;
        errors    = 0;
        items_sent = 0;
        pivots_checked = 0;
        send_idle_pct = 0;
        pop_stall_pct = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        send_item(mk(32'hFFFF_0000, 32'h0001_0000, 0, 16'd1, 1));
        test_ratio();
        test_bland();
        test_dantzig();
        test_steep();
        test_unused_and_index();
        test_mode_switch();
        test_wrap();
        test_random(0, 0, N_RANDOM / 4);
        test_random(72, 0, N_RANDOM / 4);
        test_random(0, 72, N_RANDOM / 4);
        test_random(34, 34, N_RANDOM / 4);
        drain();

        $display("covered rules 0-7, tolerance extremes, mid-vector rule changes, position wrap");
        $display("%0d elements sent, %0d pivot results checked", items_sent, pivots_checked);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/spsel_pkg.sv
hw/rtl/spsel_front.sv
hw/rtl/spsel_queue.sv
hw/rtl/spsel_back.sv
hw/rtl/simplex_pivot_selector.sv
tb/tb_simplex_pivot_selector.sv
